/* design/windowed_mean_multi_mode_assert.svh */
// windowed_mean_multi_mode_assert.svh
// assertion macros used by wmm_back; no dependencies
`ifndef WINDOWED_MEAN_MULTI_MODE_ASSERT_SVH
`define WINDOWED_MEAN_MULTI_MODE_ASSERT_SVH
`ifndef SYNTH
`define WMM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WMM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WMM_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define WMM_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

/* design/wmm_pkg.sv */
// wmm_pkg.sv
// codes, queue entry and divider types, exp2 factor table for the windowed mean block
// no dependencies
package wmm_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_REPEAT = 2'd2;

  localparam logic [1:0] MODE_ARITH = 2'd0;
  localparam logic [1:0] MODE_GEO   = 2'd1;
  localparam logic [1:0] MODE_HARM  = 2'd2;
  localparam logic [1:0] MODE_RMS   = 2'd3;

  localparam logic REG_MEAN_MODE   = 1'b0;
  localparam logic REG_WINDOW_SIZE = 1'b1;

  localparam int QDEPTH = 4;
  localparam int DIV_W  = 72;

  typedef enum logic {JOB_SAMPLE, JOB_REPEAT} job_op_t;

  typedef struct packed {
    job_op_t            op;
    logic signed [31:0] value;
    logic [3:0]         ch;
    logic               store;
    logic               last;
    logic [4:0]         len;
    logic [8:0]         n;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef logic [31:0] exp_tab_t [24];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] vv;
    r = '0;
    bt = 64'h4000_0000_0000_0000;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (vv >= r + bt) begin
        vv = vv - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // q1.31 factors 2^(2^-i), each the truncated root of the one before
  function automatic exp_tab_t exp_table();
    exp_tab_t t;
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 0; j < 24; j++) begin
      t[j] = c[31:0];
      c = isqrt64({c[32:0], 31'b0});
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

endpackage

/* design/wmm_if.sv */
// wmm_if.sv
// valid/ready channel interfaces for samples in and means out
// no dependencies
interface wmm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] sample_value;
  logic [3:0]         channel;
  logic [4:0]         list_length;
  logic [1:0]         source_kind;
  logic               last_in_list;

  modport source(output valid, command, sample_value, channel, list_length, source_kind,
                 last_in_list, input ready);
  modport sink(input valid, command, sample_value, channel, list_length, source_kind,
               last_in_list, output ready);
endinterface

interface wmm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_value;
  logic [3:0]         out_channel;
  logic               out_last;
  logic               status;

  modport source(output valid, mean_value, out_channel, out_last, status, input ready);
  modport sink(input valid, mean_value, out_channel, out_last, status, output ready);
endinterface

/* design/wmm_ram.sv */
// wmm_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module wmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/wmm_fifo.sv */
// wmm_fifo.sv
// short job queue between the front and the back
// depends on wmm_pkg
module wmm_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wmm_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output wmm_pkg::job_t head,
  output logic          empty
);
  import wmm_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/wmm_div.sv */
// wmm_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on wmm_pkg
module wmm_div (
  input  logic              clk,
  input  logic              rst,
  input  wmm_pkg::div_req_t req,
  output wmm_pkg::div_rsp_t rsp
);
  import wmm_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= CW'(DIV_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/wmm_front.sv */
// wmm_front.sv
// accepts commands, tracks list history state and queues jobs for the back
// depends on wmm_pkg, wmm_if
module wmm_front #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic          clk,
  input  logic          rst,
  wmm_in_if.sink        samples,
  input  logic [8:0]    window_size,
  input  logic          q_full,
  output logic          q_push,
  output wmm_pkg::job_t q_data
);
  import wmm_pkg::*;

  localparam int LIST_CAP = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;

  logic [8:0] lists_seen;
  logic [4:0] prev_len;
  logic [1:0] prev_kind;

  logic       accept;
  logic [4:0] len_c;
  logic       restart;
  logic [8:0] ls_eff;
  logic [9:0] ls_inc;
  logic [8:0] n_c;
  logic [8:0] ls_after;
  logic       store;

  assign samples.ready = !q_full;
  assign accept        = samples.valid && !q_full;

  always_comb begin
    if (samples.list_length == 5'd0) begin
      len_c = 5'd1;
    end else if (samples.list_length > 5'(LIST_CAP)) begin
      len_c = 5'(LIST_CAP);
    end else begin
      len_c = samples.list_length;
    end
    restart  = (len_c != prev_len) || (samples.source_kind != prev_kind);
    ls_eff   = restart ? 9'd0 : lists_seen;
    ls_inc   = {1'b0, ls_eff} + 10'd1;
    n_c      = (ls_inc > {1'b0, window_size}) ? window_size : ls_inc[8:0];
    ls_after = (ls_eff < window_size) ? ls_inc[8:0] : window_size;
    store    = ({1'b0, samples.channel} < len_c);

    q_data.op    = JOB_SAMPLE;
    q_data.value = samples.sample_value;
    q_data.ch    = samples.channel;
    q_data.store = store;
    q_data.last  = samples.last_in_list;
    q_data.len   = len_c;
    q_data.n     = n_c;
    q_push       = 1'b0;
    case (samples.command)
      CMD_SAMPLE: begin
        q_push = accept && (store || samples.last_in_list);
      end
      CMD_REPEAT: begin
        q_data.op    = JOB_REPEAT;
        q_data.store = 1'b0;
        q_data.last  = 1'b0;
        q_data.len   = prev_len;
        q_push       = accept && (lists_seen != 9'd0);
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lists_seen <= '0;
      prev_len   <= '0;
      prev_kind  <= '0;
    end else if (accept) begin
      case (samples.command)
        CMD_CLEAR: begin
          lists_seen <= '0;
        end
        CMD_SAMPLE: begin
          prev_len   <= len_c;
          prev_kind  <= samples.source_kind;
          lists_seen <= samples.last_in_list ? ls_after : ls_eff;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/wmm_back.sv */
// wmm_back.sv
// stores samples in per-channel ring windows and works out the means one channel at a time
// depends on wmm_pkg, wmm_if, windowed_mean_multi_mode_assert.svh
`include "windowed_mean_multi_mode_assert.svh"
module wmm_back #(
  parameter int MAX_WINDOW   = 256,
  parameter int MAX_CHANNELS = 16,
  parameter int RAW          = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        mean_mode,
  input  wmm_pkg::job_t     job,
  input  logic              q_empty,
  output logic              q_pop,
  wmm_out_if.source         results,
  output logic              ram_we,
  output logic [RAW-1:0]    ram_waddr,
  output logic [31:0]       ram_wdata,
  output logic [RAW-1:0]    ram_raddr,
  input  logic [31:0]       ram_rdata,
  output wmm_pkg::div_req_t div_req,
  input  wmm_pkg::div_rsp_t div_rsp
);
  import wmm_pkg::*;

  localparam int LIST_CAP = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
  localparam int CHW      = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int NCH      = 2 ** CHW;
  localparam int AW       = $clog2(MAX_WINDOW);
  localparam int FW       = $clog2(MAX_WINDOW + 1);
  localparam int CMPW     = (FW > 9) ? FW : 9;

  typedef enum logic [4:0] {
    S_IDLE, S_CH_START, S_RD, S_DATA, S_SQ_ADD, S_REC_WAIT, S_NORM, S_LOGSQ,
    S_FINAL, S_DIV_WAIT, S_POST, S_SQRT, S_EXP, S_EXP_FIN, S_OUT, S_REP_OUT
  } state_t;

  state_t state;

  logic [AW-1:0]      hd   [NCH];
  logic [FW-1:0]      fill [NCH];
  logic [32:0]        last_means [NCH];

  logic [3:0]         kk;
  logic [4:0]         cur_len;
  logic [8:0]         cur_n;
  logic [8:0]         bcnt;
  logic [AW-1:0]      rd_idx;
  logic               bvalid;
  logic signed [71:0] acc;
  logic               acc_neg;
  logic               err;
  logic [63:0]        sq;
  logic [31:0]        lg_m;
  logic [4:0]         lz;
  logic [4:0]         it;
  logic [23:0]        frac;
  logic [71:0]        quo;
  logic signed [71:0] gm;
  logic [31:0]        eacc;
  logic [63:0]        sr_v;
  logic [63:0]        sr_r;
  logic [63:0]        sr_bit;
  logic [31:0]        res_val;
  logic               res_st;

  logic               ovalid;
  logic signed [31:0] o_mean;
  logic [3:0]         o_ch;
  logic               o_last;
  logic               o_st;

  logic [CHW-1:0]     kidx;
  logic [CHW-1:0]     jch;
  logic               k_last;
  logic               out_free;
  logic signed [31:0] x_in;
  logic [31:0]        ax;
  logic [63:0]        sq_c;
  logic [63:0]        lg_p;
  logic [32:0]        lg_hi;
  logic [23:0]        frac_nx;
  logic [31:0]        lg_m_nx;
  logic [28:0]        logval;
  logic [71:0]        acc_abs;
  logic [63:0]        ex_p;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [63:0]        sr_r_nx;
  logic [63:0]        sr_v_nx;
  logic signed [71:0] sh;
  logic [31:0]        ex_sh;

  assign kidx     = kk[CHW-1:0];
  assign jch      = job.ch[CHW-1:0];
  assign k_last   = (({1'b0, kk} + 5'd1) == cur_len);
  assign out_free = !ovalid || results.ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  assign ram_we    = q_pop && (job.op == JOB_SAMPLE) && job.store;
  assign ram_waddr = {jch, hd[jch]};
  assign ram_wdata = job.value;
  assign ram_raddr = {kidx, rd_idx};

  assign results.valid       = ovalid;
  assign results.mean_value  = o_mean;
  assign results.out_channel = o_ch;
  assign results.out_last    = o_last;
  assign results.status      = o_st;

  always_comb begin
    // entries never written since reset read as zero
    x_in    = bvalid ? ram_rdata : 32'sd0;
    ax      = x_in[31] ? (~x_in + 32'd1) : x_in;
    sq_c    = ax * ax;
    lg_p    = lg_m * lg_m;
    lg_hi   = lg_p[63:31];
    frac_nx = {frac[22:0], lg_hi[32]};
    lg_m_nx = lg_hi[32] ? lg_hi[32:1] : lg_hi[31:0];
    logval  = {5'd15 - lz, frac_nx};
    acc_abs = acc[71] ? 72'(-acc) : 72'(acc);
    ex_p    = eacc * EXP_C[it];
    sq_t    = sr_r + sr_bit;
    sq_ge   = (sr_v >= sq_t);
    sr_r_nx = sq_ge ? (sr_r >> 1) + sr_bit : (sr_r >> 1);
    sr_v_nx = sq_ge ? sr_v - sq_t : sr_v;
    sh      = 72'sd15 - (gm >>> 24);
    ex_sh   = eacc >> sh[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ovalid        <= 1'b0;
      div_req.start <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        hd[c]   <= '0;
        fill[c] <= '0;
      end
    end else begin
      div_req.start <= 1'b0;
      if (ovalid && results.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur_len <= job.len;
            cur_n   <= job.n;
            kk      <= '0;
            if (job.op == JOB_REPEAT) begin
              state <= S_REP_OUT;
            end else begin
              if (job.store) begin
                hd[jch] <= (hd[jch] == AW'(MAX_WINDOW - 1)) ? '0 : hd[jch] + 1'b1;
                if (fill[jch] != FW'(MAX_WINDOW)) begin
                  fill[jch] <= fill[jch] + 1'b1;
                end
              end
              if (job.last) begin
                state <= S_CH_START;
              end
            end
          end
        end
        S_CH_START: begin
          rd_idx  <= (hd[kidx] == '0) ? AW'(MAX_WINDOW - 1) : hd[kidx] - 1'b1;
          bcnt    <= '0;
          acc     <= '0;
          err     <= 1'b0;
          res_st  <= 1'b0;
          state   <= S_RD;
        end
        S_RD: begin
          bvalid <= (CMPW'(bcnt) < CMPW'(fill[kidx]));
          state  <= (bcnt == cur_n) ? S_FINAL : S_DATA;
        end
        S_DATA: begin
          bcnt   <= bcnt + 1'b1;
          rd_idx <= (rd_idx == '0) ? AW'(MAX_WINDOW - 1) : rd_idx - 1'b1;
          case (mean_mode)
            MODE_ARITH: begin
              acc   <= acc + {{40{x_in[31]}}, x_in};
              state <= S_RD;
            end
            MODE_RMS: begin
              sq    <= sq_c;
              state <= S_SQ_ADD;
            end
            default: begin
              if (x_in[31] || x_in == 32'sd0) begin
                err   <= 1'b1;
                state <= S_FINAL;
              end else if (mean_mode == MODE_HARM) begin
                div_req.start    <= 1'b1;
                div_req.dividend <= 72'h1 << 48;
                div_req.divisor  <= {40'b0, x_in};
                state            <= S_REC_WAIT;
              end else begin
                lg_m  <= x_in;
                lz    <= '0;
                state <= S_NORM;
              end
            end
          endcase
        end
        S_SQ_ADD: begin
          acc   <= acc + {8'b0, sq};
          state <= S_RD;
        end
        S_REC_WAIT: begin
          if (div_rsp.done) begin
            acc   <= acc + div_rsp.quotient;
            state <= S_RD;
          end
        end
        S_NORM: begin
          if (lg_m[31]) begin
            it    <= '0;
            frac  <= '0;
            state <= S_LOGSQ;
          end else begin
            lg_m <= {lg_m[30:0], 1'b0};
            lz   <= lz + 1'b1;
          end
        end
        S_LOGSQ: begin
          lg_m <= lg_m_nx;
          frac <= frac_nx;
          it   <= it + 1'b1;
          if (it == 5'd23) begin
            acc   <= acc + {{43{logval[28]}}, logval};
            state <= S_RD;
          end
        end
        S_FINAL: begin
          acc_neg <= acc[71];
          if (err) begin
            res_val <= '0;
            res_st  <= 1'b1;
            state   <= S_OUT;
          end else begin
            div_req.start <= 1'b1;
            state         <= S_DIV_WAIT;
            case (mean_mode)
              MODE_ARITH: begin
                div_req.dividend <= acc_abs + {64'b0, cur_n[8:1]};
                div_req.divisor  <= {63'b0, cur_n};
              end
              MODE_GEO: begin
                div_req.dividend <= acc_abs + (acc[71] ? {63'b0, cur_n} - 72'd1 : 72'd0);
                div_req.divisor  <= {63'b0, cur_n};
              end
              MODE_HARM: begin
                div_req.dividend <= {15'b0, cur_n, 48'b0};
                div_req.divisor  <= acc;
              end
              default: begin
                div_req.dividend <= acc;
                div_req.divisor  <= {63'b0, cur_n};
              end
            endcase
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            quo   <= div_rsp.quotient;
            state <= S_POST;
          end
        end
        S_POST: begin
          case (mean_mode)
            MODE_ARITH: begin
              res_val <= acc_neg ? 32'(-quo) : quo[31:0];
              state   <= S_OUT;
            end
            MODE_HARM: begin
              res_val <= (quo > 72'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
              state   <= S_OUT;
            end
            MODE_GEO: begin
              gm    <= acc_neg ? -$signed(quo) : $signed(quo);
              eacc  <= 32'h8000_0000;
              it    <= '0;
              state <= S_EXP;
            end
            default: begin
              sr_v   <= quo[63:0];
              sr_r   <= '0;
              sr_bit <= 64'h4000_0000_0000_0000;
              it     <= '0;
              state  <= S_SQRT;
            end
          endcase
        end
        S_SQRT: begin
          sr_v   <= sr_v_nx;
          sr_r   <= sr_r_nx;
          sr_bit <= sr_bit >> 2;
          it     <= it + 1'b1;
          if (it == 5'd31) begin
            res_val <= (sr_r_nx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sr_r_nx[31:0];
            state   <= S_OUT;
          end
        end
        S_EXP: begin
          // fraction bits taken from the top down, one chain factor per cycle
          if (gm[5'd23 - it]) begin
            eacc <= ex_p[62:31];
          end
          it <= it + 1'b1;
          if (it == 5'd23) begin
            state <= S_EXP_FIN;
          end
        end
        S_EXP_FIN: begin
          if (sh < 72'sd1) begin
            res_val <= 32'h7FFF_FFFF;
          end else if (sh >= 72'sd64) begin
            res_val <= '0;
          end else begin
            res_val <= (ex_sh > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : ex_sh;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            ovalid           <= 1'b1;
            o_mean           <= res_val;
            o_ch             <= kk;
            o_last           <= k_last;
            o_st             <= res_st;
            last_means[kidx] <= {res_st, res_val};
            kk               <= kk + 1'b1;
            state            <= k_last ? S_IDLE : S_CH_START;
          end
        end
        S_REP_OUT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            o_mean <= last_means[kidx][31:0];
            o_ch   <= kk;
            o_last <= k_last;
            o_st   <= last_means[kidx][32];
            kk     <= kk + 1'b1;
            if (k_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WMM_ASSERT_IMP(a_ram_wr_idle, clk, rst, ram_we, state == S_IDLE, "window write while busy")
  `WMM_ASSERT_IMP(a_div_free, clk, rst, div_req.start, !div_rsp.busy, "divider restarted")
  `WMM_ASSERT_IMP(a_log_norm, clk, rst, state == S_LOGSQ, lg_m[31], "log mantissa not normalized")
  `WMM_ASSERT_NEXT(a_out_wait, clk, rst, state == S_OUT && ovalid && !results.ready, state == S_OUT, "result dropped")

endmodule

/* design/windowed_mean_multi_mode.sv */
// windowed_mean_multi_mode.sv
// top level: configuration registers, front, job queue, back, divider and window ram
// depends on wmm_pkg, wmm_if, wmm_ram, wmm_fifo, wmm_div, wmm_front, wmm_back
//
//  port      dir  handshake      carries
//  samples   in   valid/ready    command, sample, channel, list length, source kind, last
//  results   out  valid/ready    mean, channel, last of list, status
//  cfg       in   cfg_wr_en      register index and data, taken every enabled cycle
//
// a sample that does not end a list leaves the front in the cycle it is accepted; the queue holds four jobs
// at the end of a list each channel reads the n newest entries of its window, n the window
// in use, one at a time; a shared divider serves the final division of every mode
// (and the reciprocals in harmonic mode; log2 is worked out bit by bit per sample in geometric mode)
// reset is synchronous; no clearing pass, fill counts mask never-written window slots
// a stalled results port holds the back only; the front keeps taking jobs until the queue fills
module windowed_mean_multi_mode #(
  parameter int MAX_WINDOW   = 256,
  parameter int MAX_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  wmm_in_if.sink     samples,
  wmm_out_if.source  results,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);
  import wmm_pkg::*;

  localparam int LIST_CAP = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
  localparam int CHW      = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int AW       = $clog2(MAX_WINDOW);
  localparam int RAW      = CHW + AW;
  localparam int WCAP     = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
  localparam int WRESET   = (WCAP < 10) ? WCAP : 10;

  logic [1:0] mean_mode;
  logic [8:0] window_size;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  job_t           q_in;
  job_t           q_head;
  logic           ram_we;
  logic [RAW-1:0] ram_waddr;
  logic [31:0]    ram_wdata;
  logic [RAW-1:0] ram_raddr;
  logic [31:0]    ram_rdata;
  div_req_t       div_req;
  div_rsp_t       div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_mode   <= MODE_ARITH;
      window_size <= 9'(WRESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MEAN_MODE: begin
          mean_mode <= cfg_wdata[1:0];
        end
        REG_WINDOW_SIZE: begin
          if (cfg_wdata == 9'd0) begin
            window_size <= 9'd1;
          end else if (cfg_wdata > 9'(WCAP)) begin
            window_size <= 9'(WCAP);
          end else begin
            window_size <= cfg_wdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  wmm_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .window_size (window_size),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  wmm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  wmm_ram #(.WIDTH(32), .DEPTH(2 ** RAW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wmm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  wmm_back #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_CHANNELS (MAX_CHANNELS),
    .RAW          (RAW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mean_mode (mean_mode),
    .job       (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .results   (results),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule

/* tb/wmm_checker.sv */
// wmm_checker.sv
// watches the sample, result and register ports, predicts the means and compares them
// depends on wmm_pkg and the channel interfaces in wmm_if
module wmm_checker (
  input  logic       clk,
  input  logic       rst,
  wmm_in_if          in_ch,
  wmm_out_if         out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wmm_pkg::*;

  localparam int WIN_MAX = 256;
  localparam int CH_MAX  = 16;
  localparam longint Q24 = 64'd16777216;

  typedef struct {
    logic signed [31:0] mean;
    logic [3:0]         ch;
    logic               last;
    logic               status;
  } mean_res_t;

  mean_res_t   mean_q[$];
  logic [1:0]  mode;
  int unsigned win;
  logic [31:0] hist[CH_MAX][WIN_MAX];
  int unsigned seen;
  logic [4:0]  prev_len;
  logic [1:0]  prev_kind;
  logic [32:0] kept[CH_MAX];

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b, rem;
    r = 0;
    rem = v;
    b = 64'h4000_0000_0000_0000;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 of a positive q16.16 value as q8.24
  function automatic longint log2_fix(logic [63:0] x);
    int k;
    logic [63:0] m, frac;
    k = 0;
    frac = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = x << (31 - k);
    for (int i = 1; i <= 24; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | (64'd1 << (24 - i));
      end
    end
    return longint'(k - 16) * Q24 + longint'(frac);
  endfunction

  function automatic longint exp2_fix(longint mv);
    logic [63:0] f, acc, c;
    longint ip, s;
    f = 64'(mv) & 64'hFF_FFFF;
    ip = (mv - longint'(f)) / Q24;
    acc = 64'd1 << 31;
    c = root_floor(64'd1 << 63);
    for (int i = 1; i <= 24; i++) begin
      if (f[24 - i]) acc = (acc * c) >> 31;
      c = root_floor(c << 31);
    end
    s = 15 - ip;
    if (s < 1) return 64'd2147483647;
    if (s >= 64) return 0;
    acc = acc >> s;
    return (acc > 64'd2147483647) ? 64'd2147483647 : longint'(acc);
  endfunction

  function automatic logic [31:0] window_mean(int ch, int unsigned n, output logic err);
    longint      ssum, v, q;
    logic [127:0] wide;
    logic [63:0] a, usum, uq;
    err = 0;
    if (mode == MODE_ARITH) begin
      ssum = 0;
      for (int b = 0; b < n; b++) ssum += longint'($signed(hist[ch][b]));
      if (ssum >= 0) q = (ssum + longint'(n / 2)) / longint'(n);
      else q = -((-ssum + longint'(n / 2)) / longint'(n));
      return q[31:0];
    end
    if (mode == MODE_RMS) begin
      wide = 0;
      for (int b = 0; b < n; b++) begin
        v = longint'($signed(hist[ch][b]));
        a = (v < 0) ? 64'(-v) : 64'(v);
        wide += 128'(a * a);
      end
      wide = wide / n;
      uq = root_floor(wide[63:0]);
      return (uq > 64'd2147483647) ? 32'h7FFF_FFFF : uq[31:0];
    end
    for (int b = 0; b < n; b++) begin
      if ($signed(hist[ch][b]) <= 0) begin
        err = 1;
        return 0;
      end
    end
    if (mode == MODE_HARM) begin
      usum = 0;
      for (int b = 0; b < n; b++) usum += (64'd1 << 48) / 64'(hist[ch][b]);
      uq = (64'(n) << 48) / usum;
      return (uq > 64'd2147483647) ? 32'h7FFF_FFFF : uq[31:0];
    end
    ssum = 0;
    for (int b = 0; b < n; b++) ssum += log2_fix(64'(hist[ch][b]));
    if (ssum >= 0) q = ssum / longint'(n);
    else q = -((-ssum + longint'(n) - 1) / longint'(n));
    q = exp2_fix(q);
    return q[31:0];
  endfunction

  task automatic predict_transfer();
    logic [4:0]  len;
    int unsigned n;
    logic        err;
    logic [31:0] m;
    mean_res_t   r;
    case (in_ch.command)
      CMD_CLEAR: seen = 0;
      CMD_REPEAT: begin
        if (seen != 0) begin
          for (int k = 0; k < prev_len; k++) begin
            r.mean = kept[k][31:0];
            r.status = kept[k][32];
            r.ch = k[3:0];
            r.last = (k + 1 == prev_len);
            mean_q.push_back(r);
          end
        end
      end
      CMD_SAMPLE: begin
        len = in_ch.list_length;
        if (len < 1) len = 1;
        if (len > 16) len = 16;
        if (len != prev_len || in_ch.source_kind != prev_kind) begin
          seen = 0;
          prev_len = len;
          prev_kind = in_ch.source_kind;
        end
        if (in_ch.channel < len) begin
          for (int b = WIN_MAX - 1; b > 0; b--) hist[in_ch.channel][b] = hist[in_ch.channel][b-1];
          hist[in_ch.channel][0] = in_ch.sample_value;
        end
        if (in_ch.last_in_list) begin
          n = (seen + 1 > win) ? win : seen + 1;
          for (int k = 0; k < len; k++) begin
            m = window_mean(k, n, err);
            kept[k] = {err, m};
            r.mean = m;
            r.status = err;
            r.ch = k[3:0];
            r.last = (k + 1 == len);
            mean_q.push_back(r);
          end
          seen = (seen < win) ? seen + 1 : win;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    mode = MODE_ARITH;
    win = 10;
    seen = 0;
    prev_len = 0;
    prev_kind = 0;
    foreach (hist[i, j]) hist[i][j] = 0;
    foreach (kept[i]) kept[i] = 0;
  end

  always @(posedge clk) begin
    mean_res_t w;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (mean_q.size() == 0) begin
          report("transfer with nothing expected, channel", out_ch.out_channel, 0);
        end else begin
          w = mean_q.pop_front();
          if (out_ch.mean_value !== w.mean) report("mean_value", out_ch.mean_value, w.mean);
          if (out_ch.out_channel !== w.ch) report("out_channel", out_ch.out_channel, w.ch);
          if (out_ch.out_last !== w.last) report("out_last", out_ch.out_last, w.last);
          if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
        end
      end
      if (in_ch.valid && in_ch.ready) predict_transfer();
      if (cfg_wr_en) begin
        if (cfg_index == REG_MEAN_MODE) mode = cfg_wdata[1:0];
        else win = (cfg_wdata == 0) ? 1 : (cfg_wdata > WIN_MAX) ? WIN_MAX : cfg_wdata;
      end
      pending = mean_q.size();
    end
  end
endmodule

/* tb/tb.sv */
// tb.sv
// testbench top: clock, reset, register writes, sample stimulus and the verdict
// depends on wmm_pkg, wmm_if, wmm_checker and the windowed_mean_multi_mode design
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmm_pkg::*;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_wr_en = 0;
  logic       cfg_index = 0;
  logic [8:0] cfg_wdata = 0;
  int         fail_count, pending;
  int         sent, burst_left;
  bit         hold_go = 0;
  bit         hold_done = 0;
  int         hold_cnt = 0;
  logic [4:0] cur_len;
  logic [1:0] cur_kind;

  wmm_in_if  in_ch();
  wmm_out_if out_ch();

  windowed_mean_multi_mode DUT (
    .clk(clk), .rst(rst), .samples(in_ch), .results(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  wmm_checker mean_check (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    #1s;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: switches between random stall styles, one long hold-off on request
  initial begin
    int style, cyc;
    out_ch.ready = 0;
    cyc = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (cyc % 64 == 0) style = $urandom_range(0, 3);
      cyc++;
      if (hold_go && !hold_done) begin
        out_ch.ready <= 0;
        hold_cnt++;
        if (hold_cnt == 3000) hold_done = 1;
      end else begin
        case (style)
          0, 1: out_ch.ready <= 1;
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [31:0] val, logic [3:0] ch, logic [4:0] len,
                      logic [1:0] kind, logic last);
    int gap;
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.sample_value <= val;
    in_ch.channel <= ch;
    in_ch.list_length <= len;
    in_ch.source_kind <= kind;
    in_ch.last_in_list <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd != 2'd3) sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender pause until every expected mean has come, then a settle gap
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(logic [1:0] mode);
    int r;
    r = $urandom_range(0, 9);
    if (mode == MODE_GEO || mode == MODE_HARM) begin
      if (r == 0) return $urandom;
      if (r == 1) return 0;
      if (r < 5) return $urandom_range(1, 32'h0010_0000);
      return $urandom_range(1, 32'h7FFF_FFFF);
    end
    if (r < 3) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    return $urandom;
  endfunction

  task automatic send_list(logic [1:0] mode);
    int cnt;
    if ($urandom_range(0, 6) != 0) begin
      for (int k = 0; k < cur_len; k++)
        send(CMD_SAMPLE, rand_value(mode), k[3:0], cur_len, cur_kind, k + 1 == cur_len);
    end else begin
      // broken list: random channels, some beyond the list or missing
      cnt = $urandom_range(1, cur_len + 2);
      for (int k = 0; k < cnt; k++)
        send(CMD_SAMPLE, rand_value(mode), 4'($urandom_range(0, 15)), cur_len, cur_kind,
             k + 1 == cnt);
    end
  endtask

  initial begin
    logic [1:0] ph_mode [10] = '{MODE_RMS, MODE_GEO, MODE_HARM, MODE_ARITH, MODE_GEO,
                                 MODE_RMS, MODE_HARM, MODE_ARITH, MODE_GEO, MODE_HARM};
    logic [8:0] ph_win [10] = '{9'd1, 9'd3, 9'd5, 9'd256, 9'd0, 9'd511, 9'd2, 9'd7, 9'd16, 9'd4};
    int r, start;
    in_ch.valid = 0;
    in_ch.command = CMD_SAMPLE;
    in_ch.sample_value = 0;
    in_ch.channel = 0;
    in_ch.list_length = 1;
    in_ch.source_kind = 0;
    in_ch.last_in_list = 0;
    sent = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset registers, extremes, repeat and clear corners
    send(CMD_REPEAT, 0, 0, 1, 0, 0);
    send(CMD_SAMPLE, 32'h7FFF_FFFF, 0, 1, 0, 1);
    send(CMD_SAMPLE, 32'h8000_0000, 0, 1, 0, 1);
    send(CMD_SAMPLE, 32'hFFFF_FFFD, 0, 2, 2, 0);
    send(CMD_SAMPLE, 32'h0001_0000, 5, 2, 2, 0);
    send(CMD_SAMPLE, 32'h0003_8000, 1, 2, 2, 1);
    send(CMD_REPEAT, 0, 0, 2, 2, 0);
    send(CMD_SAMPLE, 32'h1234_5678, 15, 2, 2, 1);
    send(CMD_CLEAR, 0, 0, 2, 2, 0);
    send(CMD_REPEAT, 0, 0, 2, 2, 0);
    send(2'd3, 32'hFFFF_FFFF, 15, 16, 2, 1);
    send(CMD_SAMPLE, 32'h0000_0001, 0, 3, 1, 0);
    send(CMD_SAMPLE, 32'h0002_0000, 2, 3, 1, 1);
    send(CMD_SAMPLE, 32'hFFFF_0000, 1, 3, 1, 1);
    send(CMD_REPEAT, 0, 0, 3, 1, 0);
    drain();

    start = sent;
    cur_len = 1;
    cur_kind = 0;
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_MEAN_MODE, {7'd0, ph_mode[p]});
      write_reg(REG_WINDOW_SIZE, ph_win[p]);
      if (p == 2) hold_go = 1;
      while (sent - start < 25 * (p + 1)) begin
        if ($urandom_range(0, 5) == 0) begin
          cur_len = ($urandom_range(0, 7) == 0) ? 16 : 5'($urandom_range(1, 4));
          cur_kind = 2'($urandom_range(0, 2));
        end
        r = $urandom_range(0, 19);
        if (r == 0) send(CMD_CLEAR, $urandom, 0, cur_len, cur_kind, 0);
        else if (r < 3) send(CMD_REPEAT, $urandom, 0, cur_len, cur_kind, 0);
        else if (r == 3) send(2'd3, $urandom, 4'($urandom), cur_len, cur_kind, 1);
        else send_list(ph_mode[p]);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* windowed_mean_multi_mode.f */
+incdir+design
design/wmm_pkg.sv
design/wmm_if.sv
design/wmm_ram.sv
design/wmm_fifo.sv
design/wmm_div.sv
design/wmm_front.sv
design/wmm_back.sv
design/windowed_mean_multi_mode.sv
tb/wmm_checker.sv
tb/tb.sv
